>>> rtl/core/utf8_sentence_splitter_unit_assert.svh
// Assertion macros for the sentence splitter.
`ifndef UTF8_SENTENCE_SPLITTER_UNIT_ASSERT_SVH
`define UTF8_SENTENCE_SPLITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define USS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define USS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define USS_ASSERT_NOW(label, ante, cons)

`define USS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/uss_pkg.sv
package uss_pkg;

  localparam int SPACE_QUEUE_DEPTH_DEF = 32;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] ELL_BYTE0 = 8'hE2;
  localparam logic [7:0] ELL_BYTE1 = 8'h80;
  localparam logic [7:0] ELL_BYTE2 = 8'hA6;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] text_byte;
    logic       space_lost;
    logic       run_end;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TEXT,
    ST_MARK
  } ctl_state_t;

  typedef enum logic [1:0] {
    OSEL_INPUT,
    OSEL_QUEUE,
    OSEL_HOLD,
    OSEL_MARK
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     take_text;
    logic     take_space;
    logic     clear;
    logic     rd_start;
    logic     rd_next;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_run_end;
  } dp_cmd_t;

  typedef struct packed {
    logic is_txt;
    logic is_crlf;
    logic is_sp;
    logic open;
    logic punct;
    logic cnt_zero;
    logic flush_last;
    logic hold_fin;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/utf8_sentence_splitter_unit.sv
// UTF-8 sentence splitter.
// Input channel in_valid/in_stall/in_data carries one text byte per word with a
// flag on the last byte of a text. Output channel out_valid/out_stall/out_data
// carries sentence text bytes and end-of-sentence markers; run_end marks the
// last output word caused by one input byte.
// Timing: the output register loads at the edge that takes the input word.
// A byte that causes at most one output word leaves the controller in ST_IDLE, so
// plain text streams at one byte per clock while the receiver does not stall. A
// text byte that releases queued spaces is held; ST_FLUSH sends each space from
// the registered queue read, then ST_TEXT the held byte and, if it closes the
// text, ST_MARK a marker; ST_MARK also follows a final byte sent from ST_IDLE.
// in_stall is high while queued words or a marker are still being sent, and
// whenever the output register holds a word that the receiver stalls.
// Reset: synchronous, active low; empties the space queue (count only, the
// storage is not cleared), closes any sentence and drops the output word.
// No startup sweep is needed.
`include "utf8_sentence_splitter_unit_assert.svh"

module utf8_sentence_splitter_unit #(
  parameter int SPACE_QUEUE_DEPTH = uss_pkg::SPACE_QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uss_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output uss_pkg::out_word_t out_data
);
  import uss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  ctl_state_t state;

  uss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .final_byte (in_data.final_byte),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd),
    .state      (state)
  );

  uss_datapath #(
    .SPACE_QUEUE_DEPTH (SPACE_QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  `USS_ASSERT_NOW(a_no_take_when_blocked, in_valid && !in_stall, !out_valid || !out_stall)
  `USS_ASSERT_NOW(a_busy_stalls_input, state != ST_IDLE, in_stall)
  `USS_ASSERT_NOW(a_marker_clean, out_valid && out_data.item_kind == KIND_MARKER,
                  out_data.text_byte == 8'h00 && !out_data.space_lost && out_data.run_end)
  `USS_ASSERT_NEXT(a_flush_emits, state == ST_FLUSH && status.out_free, out_valid)

endmodule

>>> rtl/core/uss_datapath.sv
module uss_datapath #(
  parameter int SPACE_QUEUE_DEPTH = uss_pkg::SPACE_QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  uss_pkg::in_word_t   in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output uss_pkg::out_word_t  out_data,
  input  uss_pkg::dp_cmd_t    cmd,
  output uss_pkg::dp_status_t status
);
  import uss_pkg::*;

  localparam int CNT_W = $clog2(SPACE_QUEUE_DEPTH + 1);
  localparam int IDX_W = (SPACE_QUEUE_DEPTH > 1) ? $clog2(SPACE_QUEUE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SPACE_QUEUE_DEPTH);

  logic [7:0]       mem [SPACE_QUEUE_DEPTH];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             open_r, open_nxt;
  logic             punct_r, punct_nxt;
  logic [7:0]       p1_r, p1_nxt;
  logic [7:0]       p2_r, p2_nxt;
  logic [1:0]       bsc_r, bsc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       hold_byte_r, hold_byte_nxt;
  logic             hold_lost_r, hold_lost_nxt;
  logic             hold_fin_r, hold_fin_nxt;
  logic [CNT_W-1:0] flen_r, flen_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic [7:0]       b;
  logic             room;
  logic             wr_en;
  logic             rd_en;
  logic             ell;
  logic             is_punct;

  assign b        = in_data.data_byte;
  assign room     = cnt_r < DEPTH_C;
  assign wr_en    = cmd.take_space && room;
  assign rd_en    = cmd.rd_start || cmd.rd_next;
  assign ell      = (bsc_r >= 2'd2) && (p2_r == ELL_BYTE0) && (p1_r == ELL_BYTE1) &&
                    (b == ELL_BYTE2);
  assign is_punct = (b == CH_DOT) || (b == CH_BANG) || (b == CH_QUERY) || ell;

  always_comb begin
    status.is_crlf    = (b == CH_CR) || (b == CH_LF);
    status.is_sp      = (b == CH_SPACE) || (b == CH_TAB);
    status.is_txt     = !status.is_crlf && !status.is_sp;
    status.open       = open_r;
    status.punct      = punct_r;
    status.cnt_zero   = (cnt_r == '0);
    status.flush_last = ((CNT_W'(idx_r) + CNT_W'(1)) == flen_r);
    status.hold_fin   = hold_fin_r;
    status.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    open_nxt      = open_r;
    punct_nxt     = punct_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    bsc_nxt       = bsc_r;
    ovf_nxt       = ovf_r;
    hold_byte_nxt = hold_byte_r;
    hold_lost_nxt = hold_lost_r;
    hold_fin_nxt  = hold_fin_r;
    flen_nxt      = flen_r;
    idx_nxt       = idx_r;

    if (cmd.take_text || cmd.take_space) begin
      punct_nxt = is_punct;
      p2_nxt    = p1_r;
      p1_nxt    = b;
      bsc_nxt   = (bsc_r == 2'd3) ? bsc_r : bsc_r + 2'd1;
    end
    if (cmd.take_text) begin
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
      open_nxt = 1'b1;
    end
    if (cmd.take_space) begin
      if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.clear) begin
      cnt_nxt   = '0;
      open_nxt  = 1'b0;
      punct_nxt = 1'b0;
      p1_nxt    = '0;
      p2_nxt    = '0;
      bsc_nxt   = '0;
      ovf_nxt   = 1'b0;
    end

    if (cmd.accept) begin
      hold_byte_nxt = b;
      hold_lost_nxt = ovf_r;
      hold_fin_nxt  = in_data.final_byte;
      flen_nxt      = cnt_r;
    end

    if (cmd.rd_start) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
    out_data_nxt  = out_data_r;
    if (cmd.out_load) begin
      out_data_nxt.run_end = cmd.out_run_end;
      case (cmd.out_sel)
        OSEL_INPUT: begin
          out_data_nxt.item_kind  = KIND_TEXT;
          out_data_nxt.text_byte  = b;
          out_data_nxt.space_lost = ovf_r;
        end
        OSEL_QUEUE: begin
          out_data_nxt.item_kind  = KIND_TEXT;
          out_data_nxt.text_byte  = rd_data_r;
          out_data_nxt.space_lost = hold_lost_r;
        end
        OSEL_HOLD: begin
          out_data_nxt.item_kind  = KIND_TEXT;
          out_data_nxt.text_byte  = hold_byte_r;
          out_data_nxt.space_lost = hold_lost_r;
        end
        default: begin
          out_data_nxt.item_kind  = KIND_MARKER;
          out_data_nxt.text_byte  = '0;
          out_data_nxt.space_lost = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= b;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      open_r      <= 1'b0;
      punct_r     <= 1'b0;
      p1_r        <= '0;
      p2_r        <= '0;
      bsc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      punct_r     <= punct_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      bsc_r       <= bsc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_byte_r <= hold_byte_nxt;
    hold_lost_r <= hold_lost_nxt;
    hold_fin_r  <= hold_fin_nxt;
    flen_r      <= flen_nxt;
    idx_r       <= idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/uss_ctrl.sv
module uss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                final_byte,
  output logic                in_stall,
  input  uss_pkg::dp_status_t status,
  output uss_pkg::dp_cmd_t    cmd,
  output uss_pkg::ctl_state_t state
);
  import uss_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       acc;

  assign in_stall = !((state_r == ST_IDLE) && status.out_free);
  assign acc      = in_valid && !in_stall;
  assign state    = state_r;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.out_sel     = OSEL_MARK;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          if (status.is_txt) begin
            cmd.take_text = 1'b1;
            cmd.clear     = final_byte;
            if (status.cnt_zero) begin
              cmd.out_load    = 1'b1;
              cmd.out_sel     = OSEL_INPUT;
              cmd.out_run_end = !final_byte;
              state_nxt       = final_byte ? ST_MARK : ST_IDLE;
            end else begin
              cmd.rd_start = 1'b1;
              state_nxt    = ST_FLUSH;
            end
          end else if (status.is_crlf) begin
            cmd.clear       = 1'b1;
            cmd.out_load    = status.open;
            cmd.out_run_end = 1'b1;
          end else begin
            if (status.open && status.punct) begin
              cmd.clear       = 1'b1;
              cmd.out_load    = 1'b1;
              cmd.out_run_end = 1'b1;
            end else begin
              cmd.take_space  = status.open;
              cmd.clear       = final_byte;
              cmd.out_load    = status.open && final_byte;
              cmd.out_run_end = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_QUEUE;
          if (status.flush_last) begin
            state_nxt = ST_TEXT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_TEXT: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_sel     = OSEL_HOLD;
          cmd.out_run_end = !status.hold_fin;
          state_nxt       = status.hold_fin ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_run_end = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
